>>> src/sdm_pkg.sv
// shared types and constants for the sorted descending multiset
`timescale 1ns / 1ps
package sdm_pkg;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 5;
    localparam int COUNT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_FIND   = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic compare;
        logic ins;
        logic del;
        logic clr;
    } t_cell_ctrl;

endpackage

>>> src/sdm_cell.sv
// one storage cell of the sorted chain: holds an entry, compares it, shifts left or right
`timescale 1ns / 1ps
module sdm_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdm_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [sdm_pkg::VALUE_W-1:0]   i_value,
    input  logic signed [sdm_pkg::VALUE_W-1:0]   i_left_value,
    input  logic                                 i_left_valid,
    input  logic                                 i_left_gt,
    input  logic signed [sdm_pkg::VALUE_W-1:0]   i_right_value,
    input  logic                                 i_right_valid,
    output logic signed [sdm_pkg::VALUE_W-1:0]   o_value,
    output logic                                 o_valid,
    output logic                                 o_gt,
    output logic                                 o_eq,
    output logic                                 o_bnd
);
    import sdm_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic                      r_valid;
    logic                      r_gt;
    logic                      r_eq;
    logic                      bnd;

    // first cell whose entry is not greater than the key
    assign bnd = !r_gt && i_left_gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_gt    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            if (i_ctrl.compare) begin
                r_gt <= r_valid && (r_value > i_value);
                r_eq <= r_valid && (r_value == i_value);
            end
            if (i_ctrl.clr) begin
                r_valid <= 1'b0;
            end else if (i_ctrl.ins && !r_gt) begin
                if (bnd) begin
                    r_value <= i_value;
                    r_valid <= 1'b1;
                end else begin
                    r_value <= i_left_value;
                    r_valid <= i_left_valid;
                end
            end else if (i_ctrl.del && !r_gt) begin
                r_value <= i_right_value;
                r_valid <= i_right_valid;
            end
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;
    assign o_gt    = r_gt;
    assign o_eq    = r_eq;
    assign o_bnd   = bnd;

endmodule

>>> src/sdm_encoder.sv
// one-hot boundary to index encoder and match detect across the chain
`timescale 1ns / 1ps
module sdm_encoder #(
    parameter int N = 32
) (
    input  logic [N-1:0]               i_bnd,
    input  logic [N-1:0]               i_eq,
    output logic [$clog2(N)-1:0]       o_index,
    output logic                       o_hit
);
    import sdm_pkg::*;

    localparam int IW = $clog2(N);

    always_comb begin
        o_index = '0;
        o_hit   = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (i_bnd[i]) begin
                o_index = o_index | IW'(i);
            end
            o_hit = o_hit | (i_bnd[i] & i_eq[i]);
        end
    end

endmodule

>>> src/sorted_descending_multiset.sv
// top level of the sorted descending multiset: control, count and the cell chain
// result strobe o_valid is registered in the S_APPLY state, which follows the start transfer in S_IDLE
// each operation is a compare cycle then a shift cycle of the chain; start is only taken in S_IDLE
// busy is high during the shift cycle; the next start may coincide with o_valid
// results cannot be stalled and appear for exactly one cycle
// synchronous active-low reset empties the store and clears all cell valid bits
`timescale 1ns / 1ps
module sorted_descending_multiset #(
    parameter int CAPACITY = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [sdm_pkg::OP_W-1:0]            i_op,
    input  logic signed [sdm_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    output logic [sdm_pkg::STAT_W-1:0]          o_status,
    output logic [sdm_pkg::POS_W-1:0]           o_position,
    output logic [sdm_pkg::COUNT_W-1:0]         o_count
);
    import sdm_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state                    r_state;
    t_op                       r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;

    t_cell_ctrl                ctrl;
    logic signed [VALUE_W-1:0] key;
    logic                      apply;
    logic                      full;
    logic                      hit;
    logic [IW-1:0]             index;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       cell_valid;
    logic [CAPACITY-1:0]       cell_gt;
    logic [CAPACITY-1:0]       cell_eq;
    logic [CAPACITY-1:0]       cell_bnd;

    logic [STAT_W-1:0]         res_status;
    logic [IW-1:0]             res_index;
    logic [POS_W-1:0]          res_pos;
    logic [COUNT_W-1:0]        res_count;

    assign busy  = (r_state == S_APPLY);
    assign apply = (r_state == S_APPLY);
    assign full  = (r_count == CW'(CAPACITY));

    assign ctrl.compare = (r_state == S_IDLE) && start;
    assign ctrl.ins     = apply && (r_op == OP_INSERT) && !full;
    assign ctrl.del     = apply && (r_op == OP_DELETE) && hit;
    assign ctrl.clr     = apply && (r_op == OP_CLEAR);
    assign key          = ctrl.compare ? i_value : r_value;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VALUE_W-1:0] left_value;
            logic                      left_valid;
            logic                      left_gt;
            logic signed [VALUE_W-1:0] right_value;
            logic                      right_valid;

            if (g == 0) begin : g_head
                assign left_value = '0;
                assign left_valid = 1'b0;
                assign left_gt    = 1'b1;
            end else begin : g_mid
                assign left_value = cell_value[g-1];
                assign left_valid = cell_valid[g-1];
                assign left_gt    = cell_gt[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_value = '0;
                assign right_valid = 1'b0;
            end else begin : g_body
                assign right_value = cell_value[g+1];
                assign right_valid = cell_valid[g+1];
            end

            sdm_cell u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctrl        (ctrl),
                .i_value       (key),
                .i_left_value  (left_value),
                .i_left_valid  (left_valid),
                .i_left_gt     (left_gt),
                .i_right_value (right_value),
                .i_right_valid (right_valid),
                .o_value       (cell_value[g]),
                .o_valid       (cell_valid[g]),
                .o_gt          (cell_gt[g]),
                .o_eq          (cell_eq[g]),
                .o_bnd         (cell_bnd[g])
            );
        end
    endgenerate

    sdm_encoder #(
        .N (CAPACITY)
    ) u_encoder (
        .i_bnd   (cell_bnd),
        .i_eq    (cell_eq),
        .o_index (index),
        .o_hit   (hit)
    );

    always_comb begin
        res_status = ST_DONE;
        res_index  = '0;
        n_count    = r_count;
        case (r_op)
            OP_INSERT: begin
                if (full) begin
                    res_status = ST_FULL;
                end else begin
                    res_index = index;
                    n_count   = r_count + CW'(1);
                end
            end
            OP_FIND: begin
                if (hit) begin
                    res_index = index;
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_DELETE: begin
                if (hit) begin
                    res_index = index;
                    n_count   = r_count - CW'(1);
                end else begin
                    res_status = ST_NOT_FOUND;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // the result fields keep only their low bits, or are zero-extended when narrower
    generate
        if (IW >= POS_W) begin : g_pos_cut
            assign res_pos = res_index[POS_W-1:0];
        end else begin : g_pos_ext
            assign res_pos = {{(POS_W - IW){1'b0}}, res_index};
        end
        if (CW >= COUNT_W) begin : g_cnt_cut
            assign res_count = n_count[COUNT_W-1:0];
        end else begin : g_cnt_ext
            assign res_count = {{(COUNT_W - CW){1'b0}}, n_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    o_valid <= 1'b0;
                    if (start) begin
                        r_op    <= t_op'(i_op);
                        r_value <= i_value;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    o_valid    <= 1'b1;
                    o_status   <= res_status;
                    o_position <= res_pos;
                    o_count    <= res_count;
                    r_count    <= n_count;
                    r_state    <= S_IDLE;
                end
                default: begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_one_apply_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("shift cycle lasted more than one clock");

    a_result_follows_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("no result after shift cycle");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("stored count above capacity");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply && r_op == OP_INSERT && full) |=> (o_status == ST_FULL && full))
        else $error("insert into full store not refused");

    a_full_matches_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (full == cell_valid[CAPACITY-1]))
        else $error("count and last cell occupancy disagree");

endmodule
